@@ rtl/core/fscm_pkg.sv @@
// ----------------------------------------------------------------------------
// fscm_pkg: shared types and helpers for the force sensor calibration MAC
// Fixed field widths, multiplier status bundle and saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none
package fscm_pkg;

  localparam int COEF_W = 32;  // Q16.16 coefficient
  localparam int RAW_W  = 16;  // raw gauge count
  localparam int PROD_W = 64;  // full 32x32 product
  localparam int ACC_W  = 64;  // axis accumulator

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // clamp a 64-bit signed value to 32 bits signed
  function automatic logic [31:0] sat32(input logic [63:0] x);
    logic [31:0] res;
    if (!x[63] && (|x[62:31])) begin
      res = 32'h7fff_ffff;
    end else if (x[63] && !(&x[62:31])) begin
      res = 32'h8000_0000;
    end else begin
      res = x[31:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/fscm_ram.sv @@
// ----------------------------------------------------------------------------
// fscm_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module fscm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/core/fscm_smul.sv @@
// ----------------------------------------------------------------------------
// fscm_smul: bit-serial signed 32x32 multiplier
// Shift-add, one multiplier bit per cycle; MSB step subtracts.
// ----------------------------------------------------------------------------
`default_nettype none
module fscm_smul (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [31:0]        a,
  input  wire logic [31:0]        b,
  output fscm_pkg::mul_stat_t     stat,
  output logic      [63:0]        prod
);
  import fscm_pkg::*;

  logic [32:0] hi_r;
  logic [31:0] lo_r;
  logic [31:0] a_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [33:0] addend;
  logic [33:0] sum_nxt;

  always_comb begin
    addend = lo_r[0] ? {{2{a_r[31]}}, a_r} : 34'd0;
    if (cnt_r == 5'd31) begin
      sum_nxt = {hi_r[32], hi_r} - addend;   // sign bit has negative weight
    end else begin
      sum_nxt = {hi_r[32], hi_r} + addend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi_r <= 33'd0;
      lo_r <= b;
      a_r  <= a;
    end else if (busy_r) begin
      hi_r <= sum_nxt[33:1];
      lo_r <= {sum_nxt[0], lo_r[31:1]};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign prod      = {hi_r[31:0], lo_r};

endmodule
`default_nettype wire

@@ rtl/core/force_sensor_calibration_mac.sv @@
// ----------------------------------------------------------------------------
// force_sensor_calibration_mac: 6-axis style gauge-to-force calibration
// Per-channel MAC against a 3 x (N+1) matrix, then bias, 3x3 compensation,
// offset removal and Q16.16 saturation of Fx, Fy, Fz.
// ----------------------------------------------------------------------------
// Usage: load coefficients first with tuser[0]=0 requests (slot in coef_index),
// then send samples (tuser[0]=1), one channel per request, first_channel set on
// channel 0. All products go through one bit-serial 32x32 multiplier; a sample
// request runs three products plus read and accumulate steps, and no new
// request is taken until it is done. The last channel of a set adds 3 bias
// steps and 9 compensation products. A load request writes the table and the
// block stays ready. A finished result waits in the output register while
// the next requests are taken; only the end of the following set stalls on it.
// An invalid channel anywhere in the set gives zero forces with force_invalid.
// ----------------------------------------------------------------------------
`default_nettype none
module force_sensor_calibration_mac #(
  parameter int RAW_CHANNELS = 12,
  parameter int COEF_DEPTH   = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [5:0] coef_index, [37:6] coef_value, [53:38] raw_value,
  // [54] first_channel, [55] zero pad
  input  wire logic [55:0]  in_tdata,
  // [0] req_type, [1] raw_invalid
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [31:0] force_x, [63:32] force_y, [95:64] force_z
  output logic      [95:0]  out_tdata,
  // [0] force_invalid
  output logic      [0:0]   out_tuser
);
  import fscm_pkg::*;

  localparam int CAL_COLS  = RAW_CHANNELS + 1;
  localparam int COMP_BASE = 3 * CAL_COLS;
  localparam int OFS_BASE  = COMP_BASE + 9;
  localparam int AW        = $clog2(COEF_DEPTH);
  localparam int CW        = (RAW_CHANNELS > 1) ? $clog2(RAW_CHANNELS) : 1;
  // accumulators start at the rounding bias of the final >>12
  localparam logic [ACC_W-1:0] ACC_INIT = 64'd2048;
  localparam logic [65:0]      GACC_INIT = 66'h8000;

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_MAC_RD     = 4'd1;
  localparam logic [3:0] S_MAC_START  = 4'd2;
  localparam logic [3:0] S_MAC_RUN    = 4'd3;
  localparam logic [3:0] S_BIAS_RD    = 4'd4;
  localparam logic [3:0] S_BIAS_EX    = 4'd5;
  localparam logic [3:0] S_COMP_RD    = 4'd6;
  localparam logic [3:0] S_COMP_START = 4'd7;
  localparam logic [3:0] S_COMP_RUN   = 4'd8;
  localparam logic [3:0] S_OFS_RD     = 4'd9;
  localparam logic [3:0] S_OFS_EX     = 4'd10;
  localparam logic [3:0] S_EMIT       = 4'd11;

  localparam logic REQ_LOAD = 1'b0;

  // request fields
  logic [5:0]        in_coef_index;
  logic [31:0]       in_coef_value;
  logic [15:0]       in_raw_value;
  logic              in_first_channel;
  logic              in_req_type;
  logic              in_raw_invalid;
  assign in_coef_index    = in_tdata[5:0];
  assign in_coef_value    = in_tdata[37:6];
  assign in_raw_value     = in_tdata[53:38];
  assign in_first_channel = in_tdata[54];
  assign in_req_type      = in_tuser[0];
  assign in_raw_invalid   = in_tuser[1];

  logic [3:0]        state_r;
  logic [CW-1:0]     ch_r;
  logic [1:0]        r_r;
  logic [1:0]        k_r;
  logic              inv_r;
  logic [RAW_W-1:0]  raw_r;
  logic [ACC_W-1:0]  acc_r [3];
  logic [31:0]       f_r   [3];
  logic [31:0]       g_r   [3];
  logic [65:0]       gacc_r;
  logic              out_valid_r;
  logic [95:0]       out_data_r;
  logic              out_inv_r;

  logic              accept;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [COEF_W-1:0] ram_rdata;
  logic              mul_start;
  logic [31:0]       mul_b;
  mul_stat_t         mstat;
  logic [PROD_W-1:0] mul_prod;
  logic [63:0]       bias_sum;
  logic [63:0]       ofs_diff;
  logic              out_free;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // coefficient table
  assign ram_we    = accept && (in_req_type == REQ_LOAD) &&
                     ({2'b0, in_coef_index} < 8'(COEF_DEPTH));
  assign ram_waddr = AW'(in_coef_index);

  always_comb begin
    case (state_r)
      S_MAC_RD:  ram_raddr = AW'(r_r) * AW'(CAL_COLS) + AW'(ch_r);
      S_BIAS_RD: ram_raddr = AW'(r_r) * AW'(CAL_COLS) + AW'(RAW_CHANNELS);
      S_COMP_RD: ram_raddr = AW'(COMP_BASE) + AW'(r_r) * AW'(3) + AW'(k_r);
      S_OFS_RD:  ram_raddr = AW'(OFS_BASE) + AW'(r_r);
      default:   ram_raddr = '0;
    endcase
  end

  fscm_ram #(.WIDTH(COEF_W), .DEPTH(COEF_DEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_coef_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared serial multiplier: coef * raw, or comp coef * rounded force
  assign mul_start = (state_r == S_MAC_START) || (state_r == S_COMP_START);
  assign mul_b     = (state_r == S_COMP_START) ? f_r[k_r] : {{16{raw_r[15]}}, raw_r};

  fscm_smul u_smul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (ram_rdata),
    .b     (mul_b),
    .stat  (mstat),
    .prod  (mul_prod)
  );

  // bias column at weight 4096, rounding already in the accumulator
  assign bias_sum = acc_r[r_r] + {{20{ram_rdata[31]}}, ram_rdata, 12'd0};
  // compensation sum rounded to Q16.16, minus offset
  assign ofs_diff = {{14{gacc_r[65]}}, gacc_r[65:16]} - {{32{ram_rdata[31]}}, ram_rdata};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= '0;
      r_r         <= 2'd0;
      k_r         <= 2'd0;
      inv_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        acc_r[i] <= ACC_INIT;
      end
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept && (in_req_type != REQ_LOAD)) begin
            raw_r <= in_raw_value;
            r_r   <= 2'd0;
            if (in_first_channel) begin
              ch_r  <= '0;
              inv_r <= in_raw_invalid;
              for (int i = 0; i < 3; i++) begin
                acc_r[i] <= ACC_INIT;
              end
            end else begin
              inv_r <= inv_r | in_raw_invalid;
            end
            state_r <= S_MAC_RD;
          end
        end
        S_MAC_RD:    state_r <= S_MAC_START;
        S_MAC_START: state_r <= S_MAC_RUN;
        S_MAC_RUN: begin
          if (mstat.done) begin
            acc_r[r_r] <= acc_r[r_r] + mul_prod;
            if (r_r == 2'd2) begin
              r_r <= 2'd0;
              if (ch_r == CW'(RAW_CHANNELS - 1)) begin
                state_r <= S_BIAS_RD;
              end else begin
                ch_r    <= ch_r + CW'(1);
                state_r <= S_IDLE;
              end
            end else begin
              r_r     <= r_r + 2'd1;
              state_r <= S_MAC_RD;
            end
          end
        end
        S_BIAS_RD: state_r <= S_BIAS_EX;
        S_BIAS_EX: begin
          f_r[r_r] <= sat32({{12{bias_sum[63]}}, bias_sum[63:12]});
          if (r_r == 2'd2) begin
            r_r     <= 2'd0;
            k_r     <= 2'd0;
            gacc_r  <= GACC_INIT;
            state_r <= S_COMP_RD;
          end else begin
            r_r     <= r_r + 2'd1;
            state_r <= S_BIAS_RD;
          end
        end
        S_COMP_RD:    state_r <= S_COMP_START;
        S_COMP_START: state_r <= S_COMP_RUN;
        S_COMP_RUN: begin
          if (mstat.done) begin
            gacc_r <= gacc_r + {{2{mul_prod[63]}}, mul_prod};
            if (k_r == 2'd2) begin
              state_r <= S_OFS_RD;
            end else begin
              k_r     <= k_r + 2'd1;
              state_r <= S_COMP_RD;
            end
          end
        end
        S_OFS_RD: state_r <= S_OFS_EX;
        S_OFS_EX: begin
          g_r[r_r] <= sat32(ofs_diff);
          k_r      <= 2'd0;
          gacc_r   <= GACC_INIT;
          if (r_r == 2'd2) begin
            r_r     <= 2'd0;
            state_r <= S_EMIT;
          end else begin
            r_r     <= r_r + 2'd1;
            state_r <= S_COMP_RD;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_inv_r   <= inv_r;
            out_data_r  <= inv_r ? 96'd0 : {g_r[2], g_r[1], g_r[0]};
            ch_r        <= '0;
            inv_r       <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              acc_r[i] <= ACC_INIT;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_inv_r;

  // a result request is raised only by the emit step
  a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_EMIT)
    else $error("result raised outside emit step");

  // multiplier finishes only while the sequencer waits for it
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mstat.done |-> (state_r == S_MAC_RUN || state_r == S_COMP_RUN))
    else $error("multiplier result lost");

  // never start the multiplier while it is running
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mstat.busy)
    else $error("multiplier restarted while busy");

  // channel counter stays inside the set
  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    ch_r <= CW'(RAW_CHANNELS - 1))
    else $error("channel counter out of range");

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stream-level test of the force sensor calibration MAC
// Loads the coefficient table, then streams gauge sample sets, restarts and
// loads mixed in. A local predictor computes Fx/Fy/Fz per finished set; the
// monitor checks every result request against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_top;
  import fscm_pkg::*;

  localparam int CHANNELS  = 12;
  localparam int CAL_COLS  = CHANNELS + 1;
  localparam int COMP_BASE = 3 * CAL_COLS;   // 39
  localparam int OFS_BASE  = COMP_BASE + 9;  // 48
  localparam int NUM_COEF  = OFS_BASE + 3;   // 51 slots actually read
  localparam int TAIL_CYCLES = 1000;         // longer than one last-channel sample
  localparam int CYCLE_LIMIT = 2000000;
  localparam int NUM_REQS    = 1950;

  // request kinds, tuser[0]
  typedef enum logic {REQ_LOAD = 1'b0, REQ_SAMPLE = 1'b1} req_kind_e;

  typedef struct {
    req_kind_e   kind;
    logic [5:0]  idx;
    logic [31:0] coef;
    logic [15:0] raw;
    logic        bad;
    logic        first;
  } sensor_req_t;

  typedef struct {
    logic [31:0] fx, fy, fz;
    logic        bad;
  } force_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [55:0] in_tdata = '0;   // [5:0] idx, [37:6] coef, [53:38] raw, [54] first
  logic [1:0]  in_tuser = '0;   // [0] req kind, [1] raw invalid
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [95:0] out_tdata;       // [31:0] fx, [63:32] fy, [95:64] fz
  logic [0:0]  out_tuser;       // [0] force invalid

  force_sensor_calibration_mac u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  sensor_req_t pending_reqs[$];
  force_res_t  expected_forces[$];
  sensor_req_t cur_req;
  int unsigned cycle_cnt = 0;
  int unsigned mismatches = 0;

  // predictor state
  int          coef_mem[64];
  longint      axis_sum[3];
  int          chan_idx;
  bit          set_bad;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void clear_set();
    for (int r = 0; r < 3; r++) axis_sum[r] = 0;
    chan_idx = 0;
    set_bad  = 0;
  endfunction

  // apply one accepted request to the predictor; push a result when a set ends
  function automatic void calibrate_req(sensor_req_t q);
    longint raw, v, p, hi, lo, g;
    longint f[3];
    force_res_t res;
    if (q.kind == REQ_LOAD) begin
      coef_mem[q.idx] = $signed(q.coef);
      return;
    end
    if (q.first) clear_set();
    raw = longint'($signed(q.raw));
    if (q.bad) set_bad = 1;
    for (int r = 0; r < 3; r++)
      axis_sum[r] += raw * longint'(coef_mem[r * CAL_COLS + chan_idx]);
    if (chan_idx + 1 < CHANNELS) begin
      chan_idx++;
      return;
    end
    // bias column, round to Q16.16 (floor shift of signed value)
    for (int r = 0; r < 3; r++) begin
      v = axis_sum[r] + longint'(coef_mem[r * CAL_COLS + CHANNELS]) * 4096;
      f[r] = clamp32((v + 2048) >>> 12);
    end
    // compensation matrix, exact sum split into high and low halves
    for (int r = 0; r < 3; r++) begin
      hi = 0;
      lo = 0;
      for (int k = 0; k < 3; k++) begin
        p = longint'(coef_mem[COMP_BASE + r * 3 + k]) * f[k];
        hi += p >>> 16;
        lo += p & 64'hFFFF;
      end
      g = hi + ((lo + 64'h8000) >>> 16);
      g = clamp32(g - longint'(coef_mem[OFS_BASE + r]));
      case (r)
        0: res.fx = set_bad ? 32'd0 : g[31:0];
        1: res.fy = set_bad ? 32'd0 : g[31:0];
        default: res.fz = set_bad ? 32'd0 : g[31:0];
      endcase
    end
    res.bad = set_bad;
    expected_forces.push_back(res);
    clear_set();
  endfunction

  // long quiet stretch with no idling on either side
  function automatic bit take_gap();
    if (cycle_cnt > 30000 && cycle_cnt < 60000) return 0;
    return ($urandom_range(99) < 13);
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n) begin
      if (in_tvalid && in_tready) calibrate_req(cur_req);
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() > 0 && !take_gap()) begin
          cur_req = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {1'b0, cur_req.first, cur_req.raw, cur_req.coef, cur_req.idx};
          in_tuser  <= {cur_req.bad, cur_req.kind};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    force_res_t e;
    if (rst_n) begin
      out_tready <= !take_gap();
      if (out_tvalid && out_tready) begin
        if (expected_forces.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h / %b", out_tdata, out_tuser);
        end else begin
          e = expected_forces.pop_front();
          if (out_tdata !== {e.fz, e.fy, e.fx} || out_tuser[0] !== e.bad) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp fx=%h fy=%h fz=%h inv=%b got fx=%h fy=%h fz=%h inv=%b",
                       e.fx, e.fy, e.fz, e.bad, out_tdata[31:0], out_tdata[63:32],
                       out_tdata[95:64], out_tuser[0]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // ---------------- stimulus builders ----------------
  function automatic void add_load(int idx, logic [31:0] val);
    sensor_req_t q;
    q.kind = REQ_LOAD; q.idx = idx[5:0]; q.coef = val;
    q.raw = $urandom(); q.bad = $urandom_range(1); q.first = $urandom_range(1);
    pending_reqs.push_back(q);
  endfunction

  function automatic void add_sample(logic [15:0] raw, bit bad, bit first);
    sensor_req_t q;
    q.kind = REQ_SAMPLE; q.idx = $urandom(); q.coef = $urandom();
    q.raw = raw; q.bad = bad; q.first = first;
    pending_reqs.push_back(q);
  endfunction

  // mostly modest gains so results do not always saturate
  function automatic logic [31:0] rand_coef(int idx);
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return $urandom();
    if (idx >= COMP_BASE && idx < OFS_BASE)
      return 32'h0001_0000 + {{14{1'b0}}, 18'($urandom())} - 32'h0002_0000;
    return {{12{$urandom_range(1) ? 1'b1 : 1'b0}}, 20'($urandom())};
  endfunction

  function automatic void add_set(bit first_mark, int bad_ch);
    for (int c = 0; c < CHANNELS; c++) begin
      add_sample($urandom(), c == bad_ch, first_mark && c == 0);
      if ($urandom_range(99) < 4) begin
        int i;
        i = $urandom_range(63);
        add_load(i, rand_coef(i));
      end
    end
  endfunction

  initial begin
    for (int i = 0; i < 64; i++) coef_mem[i] = 0;
    clear_set();

    // full table load, unused slots up to 63 included
    for (int i = 0; i < 64; i++) add_load(i, rand_coef(i));
    // extreme raw values on every channel
    for (int c = 0; c < CHANNELS; c++) add_sample(16'h8000, 0, c == 0);
    for (int c = 0; c < CHANNELS; c++) add_sample(16'h7FFF, 0, c == 0);
    // saturating calibration gains, then a set that hits the clamps
    add_load(0, 32'h7FFF_FFFF); add_load(1, 32'h8000_0000);
    add_load(CHANNELS, 32'h7FFF_FFFF); add_load(COMP_BASE, 32'h8000_0000);
    add_load(OFS_BASE, 32'h7FFF_FFFF);
    add_set(1, -1);
    // invalid channel in the set
    add_set(1, 5);
    // restart mid-set: partial set discarded
    for (int c = 0; c < 4; c++) add_sample($urandom(), c == 2, c == 0);
    add_set(1, -1);
    // set without first mark, counter wraps on its own
    add_set(0, -1);
    for (int i = 0; i < NUM_COEF; i++) add_load(i, rand_coef(i));

    // random part, up to the total request count
    while (pending_reqs.size() < NUM_REQS) begin
      int sel;
      sel = $urandom_range(99);
      if (sel < 78) begin
        add_set($urandom_range(9) != 0, ($urandom_range(9) == 0) ? $urandom_range(11) : -1);
      end else if (sel < 88) begin
        // broken set: a few channels, then a restart follows
        for (int c = $urandom_range(1, 11); c > 0; c--)
          add_sample($urandom(), $urandom_range(19) == 0, $urandom_range(3) == 0);
        add_set(1, -1);
      end else begin
        for (int k = $urandom_range(1, 6); k > 0; k--) begin
          int i;
          i = $urandom_range(63);
          add_load(i, rand_coef(i));
        end
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() > 0 || in_tvalid || expected_forces.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_forces.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
